>>> hw/rtl/fpcr_pkg.sv
// Shared types and constants for the false-position cubic root finder.
// Used by fpcr_ctrl, fpcr_dp and the top level false_position_cubic_root.
`default_nettype none

package fpcr_pkg;

   // Constant term multiplier of the cubic f(x) = x^3 + x^2 + 3x - 3.
   localparam int CUBIC_K = 3;
   // The secant step magnitude is clamped to 2^QUOT_LOG.
   localparam int QUOT_LOG = 40;
   // Bits of the dividend walked by the restoring divider.
   localparam int DIV_STEPS = 96;
   localparam int STEP_BITS = 7;

   localparam logic [31:0] TOL_RESET = 32'd66;
   localparam logic [9:0]  LIM_RESET = 10'd100;

   typedef enum logic [0:0] {
      REG_TOL = 1'b0,
      REG_LIM = 1'b1
   } reg_type;

   typedef enum logic [1:0] {
      ST_CONV  = 2'd0,
      ST_LIMIT = 2'd1,
      ST_FLAT  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_CUB_SQ, S_CUB_LO, S_CUB_HI, S_CUB_ADD1, S_CUB_ADD2,
      S_CUB_ADD3, S_PUT, S_DIFF, S_CHECK, S_PR_LO, S_PR_HI, S_DIV_INIT,
      S_DIV, S_XCALC, S_DECIDE, S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      D_FA, D_FB, D_FX
   } dest_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_PUT_FA, OP_PUT_FB, OP_SQ, OP_CU_LO, OP_CU_HI,
      OP_ADD_SQ, OP_ADD_LIN, OP_ADD_K, OP_DIFF, OP_PR_LO, OP_PR_HI,
      OP_DIV_INIT, OP_DIV_STEP, OP_XCALC, OP_STEP, OP_COUNT, OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type kind;
   } cmd_type;

   typedef struct packed {
      logic flat;
      logic conv;
      logic limit_hit;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/fpcr_ctrl.sv
// Sequencer for the root finder: issues at most one datapath command per cycle.
// Depends on fpcr_pkg; drives fpcr_dp through cmd_type / dp_stat_type.
`default_nettype none

module fpcr_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  fpcr_pkg::dp_stat_type stat,
   output fpcr_pkg::cmd_type     cmd
);

   fpcr_pkg::state_type  state_ff, state_in;
   fpcr_pkg::dest_type   dest_ff, dest_in;
   fpcr_pkg::status_type code_ff, code_in;
   logic [fpcr_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ok;

   assign req_tready = (state_ff == fpcr_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_ok     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpcr_pkg::S_IDLE:     if (req_tvalid) state_in = fpcr_pkg::S_LOAD;
         fpcr_pkg::S_LOAD:     state_in = fpcr_pkg::S_CUB_SQ;
         fpcr_pkg::S_CUB_SQ:   state_in = fpcr_pkg::S_CUB_LO;
         fpcr_pkg::S_CUB_LO:   state_in = fpcr_pkg::S_CUB_HI;
         fpcr_pkg::S_CUB_HI:   state_in = fpcr_pkg::S_CUB_ADD1;
         fpcr_pkg::S_CUB_ADD1: state_in = fpcr_pkg::S_CUB_ADD2;
         fpcr_pkg::S_CUB_ADD2: state_in = fpcr_pkg::S_CUB_ADD3;
         fpcr_pkg::S_CUB_ADD3: begin
            state_in = (dest_ff == fpcr_pkg::D_FX) ? fpcr_pkg::S_DECIDE : fpcr_pkg::S_PUT;
         end
         fpcr_pkg::S_PUT: begin
            state_in = (dest_ff == fpcr_pkg::D_FA) ? fpcr_pkg::S_CUB_SQ : fpcr_pkg::S_DIFF;
         end
         fpcr_pkg::S_DIFF:     state_in = fpcr_pkg::S_CHECK;
         fpcr_pkg::S_CHECK: begin
            state_in = stat.flat ? fpcr_pkg::S_FINISH : fpcr_pkg::S_PR_LO;
         end
         fpcr_pkg::S_PR_LO:    state_in = fpcr_pkg::S_PR_HI;
         fpcr_pkg::S_PR_HI:    state_in = fpcr_pkg::S_DIV_INIT;
         fpcr_pkg::S_DIV_INIT: state_in = fpcr_pkg::S_DIV;
         fpcr_pkg::S_DIV: begin
            if (step_ff == fpcr_pkg::STEP_BITS'(fpcr_pkg::DIV_STEPS - 1)) begin
               state_in = fpcr_pkg::S_XCALC;
            end
         end
         fpcr_pkg::S_XCALC:    state_in = fpcr_pkg::S_CUB_SQ;
         fpcr_pkg::S_DECIDE: begin
            if (stat.conv || stat.limit_hit) state_in = fpcr_pkg::S_FINISH;
            else state_in = fpcr_pkg::S_DIFF;
         end
         fpcr_pkg::S_FINISH:   if (out_ok) state_in = fpcr_pkg::S_IDLE;
         default:              state_in = fpcr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = fpcr_pkg::OP_NONE;
      cmd.kind     = code_ff;
      dest_in      = dest_ff;
      code_in      = code_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         fpcr_pkg::S_IDLE: ;
         fpcr_pkg::S_LOAD: begin
            cmd.op  = fpcr_pkg::OP_LOAD;
            dest_in = fpcr_pkg::D_FA;
         end
         fpcr_pkg::S_CUB_SQ:   cmd.op = fpcr_pkg::OP_SQ;
         fpcr_pkg::S_CUB_LO:   cmd.op = fpcr_pkg::OP_CU_LO;
         fpcr_pkg::S_CUB_HI:   cmd.op = fpcr_pkg::OP_CU_HI;
         fpcr_pkg::S_CUB_ADD1: cmd.op = fpcr_pkg::OP_ADD_SQ;
         fpcr_pkg::S_CUB_ADD2: cmd.op = fpcr_pkg::OP_ADD_LIN;
         fpcr_pkg::S_CUB_ADD3: cmd.op = fpcr_pkg::OP_ADD_K;
         fpcr_pkg::S_PUT: begin
            if (dest_ff == fpcr_pkg::D_FA) begin
               cmd.op  = fpcr_pkg::OP_PUT_FA;
               dest_in = fpcr_pkg::D_FB;
            end else begin
               cmd.op = fpcr_pkg::OP_PUT_FB;
            end
         end
         fpcr_pkg::S_DIFF:     cmd.op = fpcr_pkg::OP_DIFF;
         fpcr_pkg::S_CHECK:    code_in = fpcr_pkg::ST_FLAT;
         fpcr_pkg::S_PR_LO:    cmd.op = fpcr_pkg::OP_PR_LO;
         fpcr_pkg::S_PR_HI:    cmd.op = fpcr_pkg::OP_PR_HI;
         fpcr_pkg::S_DIV_INIT: begin
            cmd.op  = fpcr_pkg::OP_DIV_INIT;
            step_in = '0;
         end
         fpcr_pkg::S_DIV: begin
            cmd.op  = fpcr_pkg::OP_DIV_STEP;
            step_in = step_ff + 1'b1;
         end
         fpcr_pkg::S_XCALC: begin
            cmd.op  = fpcr_pkg::OP_XCALC;
            dest_in = fpcr_pkg::D_FX;
         end
         fpcr_pkg::S_DECIDE: begin
            if (stat.conv) begin
               code_in = fpcr_pkg::ST_CONV;
            end else if (stat.limit_hit) begin
               cmd.op  = fpcr_pkg::OP_COUNT;
               code_in = fpcr_pkg::ST_LIMIT;
            end else begin
               cmd.op = fpcr_pkg::OP_STEP;
            end
         end
         fpcr_pkg::S_FINISH: begin
            if (out_ok) begin
               cmd.op       = fpcr_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpcr_pkg::S_IDLE;
         dest_ff      <= fpcr_pkg::D_FA;
         code_ff      <= fpcr_pkg::ST_CONV;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dest_ff      <= dest_in;
         code_ff      <= code_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/fpcr_dp.sv
// Datapath of the root finder: endpoints, shared 64x33 multiplier in two
// halves, restoring divider, saturating adders and the result registers.
// Depends on fpcr_pkg; commanded by fpcr_ctrl.
`default_nettype none

module fpcr_dp #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  fpcr_pkg::cmd_type     cmd,
   output fpcr_pkg::dp_stat_type stat,
   input  wire signed [31:0]     upper_end,
   input  wire signed [31:0]     lower_end,
   input  wire                   csr_wen,
   input  wire [0:0]             csr_addr,
   input  wire [31:0]            csr_wdata,
   output logic signed [31:0]    root,
   output logic signed [63:0]    residual,
   output logic [9:0]            iterations,
   output fpcr_pkg::status_type  status
);

   localparam int SH = 32 - WORD_BITS;
   localparam logic signed [42:0] X_TOP = (43'sd1 <<< (WORD_BITS - 1)) - 43'sd1;
   localparam logic signed [42:0] X_BOT = -(43'sd1 <<< (WORD_BITS - 1));
   localparam logic signed [63:0] K_OFF = 64'(fpcr_pkg::CUBIC_K) <<< FRAC_BITS;
   localparam logic [95:0] Q_CLAMP = 96'd1 << fpcr_pkg::QUOT_LOG;
   localparam logic signed [63:0] I64_MAX = {1'b0, {63{1'b1}}};

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
      logic signed [64:0] s;
      s = 65'(x) + 65'(y);
      if (s[64] != s[63]) sat_add = s[64] ? ~I64_MAX : I64_MAX;
      else sat_add = s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
      logic signed [64:0] s;
      s = 65'(x) - 65'(y);
      if (s[64] != s[63]) sat_sub = s[64] ? ~I64_MAX : I64_MAX;
      else sat_sub = s[63:0];
   endfunction

   logic signed [31:0] a_ff, a_in, b_ff, b_in, cx_ff, cx_in;
   logic signed [63:0] fa_ff, fa_in, fb_ff, fb_in, f_ff, f_in, diff_ff, diff_in;
   logic signed [32:0] span_ff, span_in;
   logic [63:0] sq_ff, sq_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [96:0] prod_ff, prod_in;
   logic [95:0] dv_ff, dv_in;
   logic [9:0]  count_ff, count_in, lim_ff;
   logic [31:0] tol_ff;
   logic signed [31:0] root_ff, root_in;
   logic signed [63:0] res_ff, res_in;
   logic [9:0]  iter_ff, iter_in;
   fpcr_pkg::status_type stat_ff, stat_in;

   logic signed [31:0] a_ext, b_ext;
   logic [31:0] cm;
   logic [63:0] fa_mag, f_mag, diff_mag, sq_w, mul_a;
   logic [32:0] span_mag, mul_b;
   logic [31:0] mul_half;
   logic [64:0] pp;
   logic [96:0] shifted;
   logic signed [63:0] cube, lin;
   logic [64:0] div_r;
   logic div_ge;
   logic [40:0] qm;
   logic q_neg;
   logic signed [42:0] qs, xw, xc;

   assign a_ext = (upper_end <<< SH) >>> SH;
   assign b_ext = (lower_end <<< SH) >>> SH;
   assign cm       = cx_ff[31] ? 32'(-cx_ff) : 32'(cx_ff);
   assign fa_mag   = fa_ff[63] ? 64'(-fa_ff) : 64'(fa_ff);
   assign f_mag    = f_ff[63] ? 64'(-f_ff) : 64'(f_ff);
   assign diff_mag = diff_ff[63] ? 64'(-diff_ff) : 64'(diff_ff);
   assign span_mag = span_ff[32] ? 33'(-span_ff) : 33'(span_ff);
   assign shifted  = prod_ff >> FRAC_BITS;
   assign sq_w     = shifted[63:0];
   assign lin      = (64'(cx_ff) <<< 1) + 64'(cx_ff);

   // Cube magnitude saturates to the largest int64, then takes the sign of x.
   always_comb begin
      logic signed [63:0] cmag;
      cmag = (|shifted[96:63]) ? I64_MAX : $signed({1'b0, shifted[62:0]});
      cube = cx_ff[31] ? -cmag : cmag;
   end

   // Multiplier operand selection; the high half is added in a second pass.
   always_comb begin
      mul_a = {32'd0, cm};
      mul_b = {1'b0, cm};
      case (cmd.op)
         fpcr_pkg::OP_CU_LO: mul_a = sq_w;
         fpcr_pkg::OP_CU_HI: mul_a = sq_ff;
         fpcr_pkg::OP_PR_LO, fpcr_pkg::OP_PR_HI: begin
            mul_a = fa_mag;
            mul_b = span_mag;
         end
         default: ;
      endcase
      mul_half = (cmd.op == fpcr_pkg::OP_CU_HI || cmd.op == fpcr_pkg::OP_PR_HI)
                 ? mul_a[63:32] : mul_a[31:0];
      pp = 65'(mul_half) * 65'(mul_b);
   end

   assign div_r  = {rem_ff, dv_ff[95]};
   assign div_ge = div_r >= {1'b0, dsr_ff};

   always_comb begin
      qm    = (dv_ff > Q_CLAMP) ? Q_CLAMP[40:0] : dv_ff[40:0];
      q_neg = ((fa_ff < 0) != (span_ff < 0)) != (diff_ff < 0);
      qs    = q_neg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
      xw    = 43'(a_ff) - qs;
      if (xw > X_TOP) xc = X_TOP;
      else if (xw < X_BOT) xc = X_BOT;
      else xc = xw;
   end

   always_comb begin
      a_in = a_ff; b_in = b_ff; cx_in = cx_ff;
      fa_in = fa_ff; fb_in = fb_ff; f_in = f_ff; diff_in = diff_ff;
      span_in = span_ff; sq_in = sq_ff; rem_in = rem_ff; dsr_in = dsr_ff;
      prod_in = prod_ff; dv_in = dv_ff; count_in = count_ff;
      root_in = root_ff; res_in = res_ff; iter_in = iter_ff; stat_in = stat_ff;
      case (cmd.op)
         fpcr_pkg::OP_LOAD: begin
            a_in = a_ext; b_in = b_ext; cx_in = a_ext; count_in = '0;
         end
         fpcr_pkg::OP_PUT_FA: begin
            fa_in = f_ff; cx_in = b_ff;
         end
         fpcr_pkg::OP_PUT_FB: fb_in = f_ff;
         fpcr_pkg::OP_SQ:     prod_in = 97'(pp);
         fpcr_pkg::OP_CU_LO: begin
            sq_in = sq_w; prod_in = 97'(pp);
         end
         fpcr_pkg::OP_CU_HI, fpcr_pkg::OP_PR_HI: prod_in = prod_ff + {pp, 32'd0};
         fpcr_pkg::OP_PR_LO:   prod_in = 97'(pp);
         fpcr_pkg::OP_ADD_SQ:  f_in = sat_add(cube, $signed(sq_ff));
         fpcr_pkg::OP_ADD_LIN: f_in = sat_add(f_ff, lin);
         fpcr_pkg::OP_ADD_K:   f_in = sat_sub(f_ff, K_OFF);
         fpcr_pkg::OP_DIFF: begin
            diff_in = sat_sub(fa_ff, fb_ff);
            span_in = 33'(a_ff) - 33'(b_ff);
         end
         fpcr_pkg::OP_DIV_INIT: begin
            dv_in = prod_ff[95:0]; rem_in = '0; dsr_in = diff_mag;
         end
         fpcr_pkg::OP_DIV_STEP: begin
            rem_in = div_ge ? 64'(div_r - {1'b0, dsr_ff}) : div_r[63:0];
            dv_in  = {dv_ff[94:0], div_ge};
         end
         fpcr_pkg::OP_XCALC: cx_in = xc[31:0];
         fpcr_pkg::OP_COUNT: count_in = count_ff + 1'b1;
         fpcr_pkg::OP_STEP: begin
            count_in = count_ff + 1'b1;
            if ((fb_ff > 0 && f_ff > 0) || (fb_ff < 0 && f_ff < 0)) begin
               b_in = cx_ff; fb_in = f_ff;
            end else begin
               a_in = cx_ff; fa_in = f_ff;
            end
         end
         fpcr_pkg::OP_OUT: begin
            iter_in = count_ff;
            stat_in = cmd.kind;
            if (cmd.kind == fpcr_pkg::ST_FLAT) begin
               root_in = a_ff; res_in = fa_ff;
            end else begin
               root_in = cx_ff; res_in = f_ff;
            end
         end
         default: ;
      endcase
   end

   assign stat.flat      = (diff_ff == '0);
   assign stat.conv      = f_mag < {32'd0, tol_ff};
   assign stat.limit_hit = ({1'b0, count_ff} + 11'd1) >= {1'b0, lim_ff};

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; cx_ff <= cx_in;
      fa_ff <= fa_in; fb_ff <= fb_in; f_ff <= f_in; diff_ff <= diff_in;
      span_ff <= span_in; sq_ff <= sq_in; rem_ff <= rem_in; dsr_ff <= dsr_in;
      prod_ff <= prod_in; dv_ff <= dv_in; count_ff <= count_in;
      root_ff <= root_in; res_ff <= res_in; iter_ff <= iter_in; stat_ff <= stat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= fpcr_pkg::TOL_RESET;
         lim_ff <= fpcr_pkg::LIM_RESET;
      end else if (csr_wen) begin
         if (csr_addr == fpcr_pkg::REG_TOL) tol_ff <= csr_wdata;
         else lim_ff <= csr_wdata[9:0];
      end
   end

   assign root       = root_ff;
   assign residual   = res_ff;
   assign iterations = iter_ff;
   assign status     = stat_ff;

endmodule

`default_nettype wire

>>> hw/rtl/false_position_cubic_root.sv
// False-position root finder for f(x) = x^3 + x^2 + 3x - 3 in signed fixed point.
// After acceptance the sequencer loads both endpoints and evaluates the cubic at each.
// Every secant step then forms f(a) - f(b), stops on a flat secant, multiplies f(a) by
// the span in two halves, runs the one-bit-per-cycle restoring divider, computes the new
// x, evaluates the cubic there and decides whether to finish or to move an endpoint. The
// finish state registers the result, waiting while a previous result is still held.
// One word is in flight; the request side is ready again once the result is registered,
// even while that result waits. Reset (synchronous, active high) clears the sequencer and
// restores tolerance 66 and iteration limit 100. Depends on fpcr_pkg, fpcr_ctrl and fpcr_dp.
`default_nettype none

module false_position_cubic_root #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [63:0]  req_tdata,   // upper_end [31:0], lower_end [63:32]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [111:0] rsp_tdata,   // root [31:0], residual [95:32], iterations [105:96]
   output logic [1:0]   rsp_tuser,   // status [1:0]
   input  wire          csr_wen,
   input  wire  [0:0]   csr_addr,
   input  wire  [31:0]  csr_wdata
);

   fpcr_pkg::cmd_type     cmd;
   fpcr_pkg::dp_stat_type stat;
   logic signed [31:0]    root;
   logic signed [63:0]    residual;
   logic [9:0]            iterations;
   fpcr_pkg::status_type  status;

   // The sequencer owns the handshakes; the datapath only executes commands.
   fpcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Endpoints are sampled by the load command, issued the cycle after the
   // word is accepted; the request side is not ready again until the result
   // has been registered, so the input word is still stable for the sample
   // only if the source holds it, hence the top level registers it at acceptance.
   logic signed [31:0] upper_ff, lower_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         upper_ff <= $signed(req_tdata[31:0]);
         lower_ff <= $signed(req_tdata[63:32]);
      end
   end

   fpcr_dp #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .upper_end  (upper_ff),
      .lower_end  (lower_ff),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .root       (root),
      .residual   (residual),
      .iterations (iterations),
      .status     (status)
   );

   // The result word is packed from the datapath's output registers.
   assign rsp_tdata = {6'd0, iterations, residual, root};
   assign rsp_tuser = status;

endmodule

`default_nettype wire
